[rtl/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants of the Bezier point evaluator
// Holds the beat formats, the request and status codes, the sequencer
// states and the control group that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int COORD_BITS  = 12;
    localparam int T_FRAC_BITS = 16;

    localparam int T_W    = T_FRAC_BITS + 1;
    localparam int WORK_W = COORD_BITS + T_FRAC_BITS;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [T_W-1:0]        t_param;
    } bpe_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [COORD_BITS-1:0] curve_x;
        logic [COORD_BITS-1:0] curve_y;
        logic [CNT_W-1:0]      points_held;
    } bpe_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_FINISH
    } bpe_state_t;

    typedef struct packed {
        logic             store_we;
        logic [IDX_W-1:0] store_idx;
        logic             t_we;
        logic             load;
        logic             step;
        logic             dbl;
        logic [IDX_W-1:0] wr_idx;
    } bpe_ctrl_t;

endpackage

[rtl/bpe_lerp.sv]
// ----------------------------------------------------------------------------
// bpe_lerp: one linear interpolation step
// Computes a + floor((b - a) * t / 2^T_FRAC_BITS) on unsigned fixed point.
// ----------------------------------------------------------------------------
module bpe_lerp
    import bpe_pkg::*;
(
    input  logic [WORK_W-1:0] a,
    input  logic [WORK_W-1:0] b,
    input  logic [T_W-1:0]    t,
    output logic [WORK_W-1:0] y
);

    localparam int PROD_W = WORK_W + T_W + 2;

    logic signed [WORK_W:0]   diff;
    logic signed [T_W:0]      t_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;

    // The arithmetic shift of the signed product gives the floor for both signs.
    assign diff   = signed'({1'b0, b}) - signed'({1'b0, a});
    assign t_s    = signed'({1'b0, t});
    assign prod   = PROD_W'(diff) * PROD_W'(t_s);
    assign scaled = prod >>> T_FRAC_BITS;

    // The true result lies between a and b, so the sum wraps back into range.
    assign y = a + scaled[WORK_W-1:0];

endmodule

[rtl/bpe_datapath.sv]
// ----------------------------------------------------------------------------
// bpe_datapath: control point store, working row and interpolation unit
// The working row shifts toward entry zero while the interpolation unit
// reads the first two entries and writes its result at the end of a level.
// ----------------------------------------------------------------------------
module bpe_datapath
    import bpe_pkg::*;
(
    input  logic                  clk,
    input  bpe_ctrl_t             ctrl,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic [T_W-1:0]        t_param,
    output logic [COORD_BITS-1:0] head_x,
    output logic [COORD_BITS-1:0] head_y
);

    logic [COORD_BITS-1:0] x_store [MAX_POINTS];
    logic [COORD_BITS-1:0] y_store [MAX_POINTS];
    logic [WORK_W-1:0]     work_x_reg [MAX_POINTS];
    logic [WORK_W-1:0]     work_y_reg [MAX_POINTS];
    logic [WORK_W-1:0]     shift_x [MAX_POINTS];
    logic [WORK_W-1:0]     shift_y [MAX_POINTS];
    logic [T_W-1:0]        t_reg;
    logic [T_W-1:0]        t_sat;
    logic [WORK_W-1:0]     lerp_x;
    logic [WORK_W-1:0]     lerp_y;

    assign t_sat = (t_param > T_ONE) ? T_ONE : t_param;

    // Each entry takes its neighbor one or two places up; the top entry holds.
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_shift
        if (k + 2 < MAX_POINTS) begin : g_mid
            assign shift_x[k] = ctrl.dbl ? work_x_reg[k+2] : work_x_reg[k+1];
            assign shift_y[k] = ctrl.dbl ? work_y_reg[k+2] : work_y_reg[k+1];
        end
        else if (k + 1 < MAX_POINTS) begin : g_near
            assign shift_x[k] = work_x_reg[k+1];
            assign shift_y[k] = work_y_reg[k+1];
        end
        else begin : g_top
            assign shift_x[k] = work_x_reg[k];
            assign shift_y[k] = work_y_reg[k];
        end
    end

    bpe_lerp u_lerp_x (
        .a (work_x_reg[0]),
        .b (work_x_reg[1]),
        .t (t_reg),
        .y (lerp_x)
    );

    bpe_lerp u_lerp_y (
        .a (work_y_reg[0]),
        .b (work_y_reg[1]),
        .t (t_reg),
        .y (lerp_y)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.store_we)
        begin
            x_store[ctrl.store_idx] <= point_x;
            y_store[ctrl.store_idx] <= point_y;
        end
        if (ctrl.t_we)
        begin
            t_reg <= t_sat;
        end
        if (ctrl.load)
        begin
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                work_x_reg[k] <= {x_store[k], T_FRAC_BITS'(0)};
                work_y_reg[k] <= {y_store[k], T_FRAC_BITS'(0)};
            end
        end
        else if (ctrl.step)
        begin
            // The addressed entry takes the new point; all others shift.
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                if (IDX_W'(k) == ctrl.wr_idx)
                begin
                    work_x_reg[k] <= lerp_x;
                    work_y_reg[k] <= lerp_y;
                end
                else
                begin
                    work_x_reg[k] <= shift_x[k];
                    work_y_reg[k] <= shift_y[k];
                end
            end
        end
    end

    assign head_x = work_x_reg[0][WORK_W-1:T_FRAC_BITS];
    assign head_y = work_y_reg[0][WORK_W-1:T_FRAC_BITS];

endmodule

[rtl/bpe_seq.sv]
// ----------------------------------------------------------------------------
// bpe_seq: request decoder and evaluation sequencer
// Keeps the point count, walks the de Casteljau levels and builds the result.
// ----------------------------------------------------------------------------
module bpe_seq
    import bpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            req_type,
    input  logic [COORD_BITS-1:0] head_x,
    input  logic [COORD_BITS-1:0] head_y,
    input  logic                  res_take,
    output logic                  in_ready,
    output bpe_ctrl_t             ctrl,
    output logic                  res_valid,
    output bpe_out_t              res
);

    bpe_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] level_reg, level_next;
    logic [IDX_W-1:0] step_reg, step_next;
    bpe_out_t         res_reg, res_next;
    logic [CNT_W-1:0] level_m1;
    logic [CNT_W-1:0] level_m2;

    assign level_m1 = level_reg - CNT_W'(1);
    assign level_m2 = level_reg - CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            level_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            level_reg <= level_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        level_next = level_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next             = '0;
                    res_next.points_held = count_reg;
                    state_next           = ST_FINISH;
                    unique case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next           = '0;
                            res_next.points_held = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_POINTS))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.store_we        = 1'b1;
                                ctrl.store_idx       = count_reg[IDX_W-1:0];
                                count_next           = count_reg + CNT_W'(1);
                                res_next.points_held = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.t_we  = 1'b1;
                                level_next = count_reg;
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                step_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (level_reg == CNT_W'(1))
                begin
                    res_next.status      = ST_OK;
                    res_next.curve_x     = head_x;
                    res_next.curve_y     = head_y;
                    res_next.points_held = count_reg;
                    state_next           = ST_FINISH;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    if (CNT_W'(step_reg) == level_m2)
                    begin
                        // Last pair of the level: close the gap left by the old tail.
                        ctrl.dbl    = 1'b1;
                        ctrl.wr_idx = level_m2[IDX_W-1:0];
                        level_next  = level_m1;
                        step_next   = '0;
                    end
                    else
                    begin
                        ctrl.wr_idx = level_m1[IDX_W-1:0];
                        step_next   = step_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store size");

    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && req_type == REQ_EVAL && count_reg != '0)
        |=> state_reg == ST_LOAD)
        else $error("evaluate on a filled store did not start loading");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD || state_reg == ST_STEP)
        |-> (level_reg != '0 && level_reg <= count_reg))
        else $error("level outside the stored point range");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && level_reg > CNT_W'(1))
        |-> (CNT_W'(step_reg) + CNT_W'(2)) <= level_reg)
        else $error("step index ran past the current level");

endmodule

[rtl/bezier_point_eval.sv]
// ----------------------------------------------------------------------------
// bezier_point_eval: Bezier control point store with de Casteljau evaluation
// Stores up to MAX_POINTS control points and evaluates the curve at a
// parameter t in Q1.16 by repeated linear interpolation in fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Beat type   Contents
//  in        in_valid / in_ready    bpe_in_t    request, point, parameter t
//  out       out_valid / out_ready  bpe_out_t   status, curve point, count
//
// A clear or an append goes from idle to the finish state; its result is
// registered in the sequencer on acceptance and then moves into the output
// register. An evaluate over n points goes through the load state and then
// n*(n-1)/2 interpolation steps before its result is registered; the single
// x/y interpolation unit does one step per cycle on the first two entries of
// the shifting working row.
// The input is not ready while an item is in flight. A stalled output holds
// one beat in the output register and at most one more finished beat in the
// sequencer, and the input stays blocked until that second beat moves on.
// Reset clears the point count and the handshake state; the point store and
// the working row come up undefined; unwritten entries never reach a result.
module bezier_point_eval
    import bpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bpe_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output bpe_out_t out_data
);

    bpe_ctrl_t             ctrl;
    logic [COORD_BITS-1:0] head_x;
    logic [COORD_BITS-1:0] head_y;
    logic                  res_valid;
    logic                  res_take;
    bpe_out_t              res;
    logic                  out_valid_reg;
    bpe_out_t              out_data_reg;

    // The sequencer owns request decoding and the level walk.
    bpe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (in_data.req_type),
        .head_x    (head_x),
        .head_y    (head_y),
        .res_take  (res_take),
        .in_ready  (in_ready),
        .ctrl      (ctrl),
        .res_valid (res_valid),
        .res       (res)
    );

    // The datapath holds the points, the working row and the interpolator.
    bpe_datapath u_datapath (
        .clk     (clk),
        .ctrl    (ctrl),
        .point_x (in_data.point_x),
        .point_y (in_data.point_y),
        .t_param (in_data.t_param),
        .head_x  (head_x),
        .head_y  (head_y)
    );

    // A finished result moves into the output register whenever that register
    // is empty or is being drained in the same cycle.
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[verif/tb_bezier_point_eval.sv]
// ----------------------------------------------------------------------------
// tb_bezier_point_eval: self-checking testbench of the Bezier point evaluator
// Runs a short table of directed beats and then randomized request sequences
// (clear, fill the store, evaluate at many parameters) with random idle and
// stall bursts on both channels. Every result beat is checked field by field
// against a typed-in beat or a fixed-point de Casteljau predictor in the testbench.
// ----------------------------------------------------------------------------
module tb_bezier_point_eval
    import bpe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The request code that the block has no use for; it must change nothing.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_BEATS = 1700;
    // The last beats of the run go without any idling on either side.
    localparam int CALM_TAIL    = 200;
    // The drain wait leaves headroom above the longest evaluate.
    localparam int DRAIN_CYCLES = 160;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    bpe_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    bpe_out_t out_data;

    bezier_point_eval DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // One row of the directed table. When has_fixed is set, the expected beat
    // is the typed-in one; otherwise the predictor supplies it.
    typedef struct {
        bpe_in_t  beat;
        bit       has_fixed;
        bpe_out_t fixed_result;
    } directed_row_t;

    directed_row_t directed_rows[$];

    // Predictor state: a private copy of the control point store and count.
    logic [COORD_BITS-1:0] pts_x [MAX_POINTS];
    logic [COORD_BITS-1:0] pts_y [MAX_POINTS];
    int                    pts_count = 0;

    // Result beats owed by the block, oldest first.
    bpe_out_t curve_results_due[$];

    bit idle_on = 1'b0;
    int beats_sent = 0;
    int beats_checked = 0;
    int mismatch_count = 0;
    int evals_done = 0;
    int evals_empty = 0;
    int appends_refused = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic bpe_out_t result_of(logic [1:0] status, logic [COORD_BITS-1:0] cx,
                                           logic [COORD_BITS-1:0] cy, int count);
        bpe_out_t r;
        r.status      = status;
        r.curve_x     = cx;
        r.curve_y     = cy;
        r.points_held = CNT_W'(count);
        return r;
    endfunction

    // Works out the result of one accepted beat and advances the predictor
    // state. Each interpolation step is a + floor((b - a) * t / 2^16); the
    // arithmetic right shift of a signed product gives exactly that floor,
    // negative differences included.
    function automatic bpe_out_t predict_curve_point(bpe_in_t b);
        bpe_out_t r;
        longint   wx [MAX_POINTS];
        longint   wy [MAX_POINTS];
        longint   t_sat;
        int       lvl;
        int       i;
        r = '0;
        case (b.req_type)
            REQ_CLEAR: pts_count = 0;
            REQ_APPEND:
            begin
                if (pts_count >= MAX_POINTS)
                begin
                    r.status = ST_FULL;
                    appends_refused++;
                end
                else
                begin
                    pts_x[pts_count] = b.point_x;
                    pts_y[pts_count] = b.point_y;
                    pts_count++;
                end
            end
            REQ_EVAL:
            begin
                if (pts_count == 0)
                begin
                    r.status = ST_EMPTY;
                    evals_empty++;
                end
                else
                begin
                    // Parameters above one saturate to exactly one.
                    t_sat = (b.t_param > T_ONE) ? longint'(T_ONE) : longint'(b.t_param);
                    for (i = 0; i < pts_count; i++)
                    begin
                        wx[i] = longint'(pts_x[i]) << T_FRAC_BITS;
                        wy[i] = longint'(pts_y[i]) << T_FRAC_BITS;
                    end
                    for (lvl = pts_count; lvl > 1; lvl--)
                    begin
                        for (i = 0; i + 1 < lvl; i++)
                        begin
                            wx[i] = wx[i] + (((wx[i+1] - wx[i]) * t_sat) >>> T_FRAC_BITS);
                            wy[i] = wy[i] + (((wy[i+1] - wy[i]) * t_sat) >>> T_FRAC_BITS);
                        end
                    end
                    r.curve_x = wx[0][T_FRAC_BITS +: COORD_BITS];
                    r.curve_y = wy[0][T_FRAC_BITS +: COORD_BITS];
                    evals_done++;
                end
            end
            default: ;
        endcase
        r.points_held = CNT_W'(pts_count);
        return r;
    endfunction

    // Presents one input beat, holding it until accepted. An idle burst may
    // come first; valid otherwise stays high from one beat to the next.
    task automatic send_beat(input bpe_in_t b, input bit has_fixed, input bpe_out_t fixed_result);
        bpe_out_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_curve_point(b);
        curve_results_due = {curve_results_due, (has_fixed ? fixed_result : predicted)};
        beats_sent++;
    endtask

    function automatic void add_row(logic [1:0] req, logic [COORD_BITS-1:0] px,
                                    logic [COORD_BITS-1:0] py, logic [T_W-1:0] t,
                                    bit has_fixed, bpe_out_t fixed_result);
        directed_row_t row;
        row.beat.req_type  = req;
        row.beat.point_x   = px;
        row.beat.point_y   = py;
        row.beat.t_param   = t;
        row.has_fixed      = has_fixed;
        row.fixed_result   = fixed_result;
        directed_rows      = {directed_rows, row};
    endfunction

    // Directed table: empty store, unused code, single point, two-point
    // extremes with saturated t, a full store, a refused append, and a clear.
    function automatic void build_directed_table();
        int k;
        add_row(REQ_EVAL,   12'hFFF, 12'hFFF, 17'h1FFFF, 1'b1, result_of(ST_EMPTY, '0, '0, 0));
        add_row(REQ_UNUSED, 12'hFFF, 12'hFFF, 17'h1FFFF, 1'b1, result_of(ST_OK, '0, '0, 0));
        add_row(REQ_APPEND, 12'hFFF, 12'h000, 17'h1FFFF, 1'b1, result_of(ST_OK, '0, '0, 1));
        // A single point comes back unchanged whatever t is.
        add_row(REQ_EVAL,   12'h000, 12'h000, 17'h1FFFF, 1'b1,
                result_of(ST_OK, 12'hFFF, '0, 1));
        add_row(REQ_APPEND, 12'h000, 12'hFFF, 17'h00000, 1'b1, result_of(ST_OK, '0, '0, 2));
        add_row(REQ_EVAL,   12'hFFF, 12'hFFF, 17'h00000, 1'b1,
                result_of(ST_OK, 12'hFFF, '0, 2));
        add_row(REQ_EVAL,   12'h000, 12'h000, 17'h10001, 1'b1,
                result_of(ST_OK, '0, 12'hFFF, 2));
        add_row(REQ_EVAL,   12'h000, 12'h000, 17'h08000, 1'b0, '0);
        // Fill the store to the top with alternating bit patterns.
        for (k = 2; k < MAX_POINTS; k++)
        begin
            add_row(REQ_APPEND, (k % 2) ? 12'hAAA : 12'h555, (k % 2) ? 12'h555 : 12'hAAA,
                    17'h0AAAA, 1'b1, result_of(ST_OK, '0, '0, k + 1));
        end
        add_row(REQ_APPEND, 12'h123, 12'h456, 17'h00000, 1'b1,
                result_of(ST_FULL, '0, '0, MAX_POINTS));
        add_row(REQ_EVAL,   12'h000, 12'h000, 17'h05555, 1'b0, '0);
        add_row(REQ_EVAL,   12'h000, 12'h000, T_ONE,     1'b0, '0);
        add_row(REQ_CLEAR,  12'hFFF, 12'hFFF, 17'h1FFFF, 1'b1, result_of(ST_OK, '0, '0, 0));
        add_row(REQ_EVAL,   12'hFFF, 12'hFFF, 17'h1FFFF, 1'b1, result_of(ST_EMPTY, '0, '0, 0));
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    // Mostly in-range parameters, with the ends and saturating values mixed in.
    function automatic logic [T_W-1:0] rand_t();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return T_ONE;
            2:       return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
            default: return T_W'($urandom_range(0, T_ONE - 1));
        endcase
    endfunction

    // Fields that the request does not use are random too; the block must
    // ignore them.
    function automatic bpe_in_t rand_beat(logic [1:0] req);
        bpe_in_t b;
        b.req_type = req;
        b.point_x  = rand_coord();
        b.point_y  = rand_coord();
        b.t_param  = rand_t();
        return b;
    endfunction

    // Random part. Most sequences are well formed: usually a clear, a run of appends
    // (usually a few points, now and then close to a full store) and several
    // evaluates. The rest overfill the store, evaluate an empty one, or throw
    // raw beats of any request code.
    task automatic run_random_sequences(input int target);
        int start;
        int kind;
        int n_pts;
        int n_eval;
        int n_over;
        int n_raw;
        int j;
        start = beats_sent;
        while (beats_sent - start < target)
        begin
            idle_on = (beats_sent - start < target - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_beat(rand_beat(REQ_CLEAR), 1'b0, '0);
                n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(12, MAX_POINTS)
                                                    : $urandom_range(1, 6);
                for (j = 0; j < n_pts; j++)
                    send_beat(rand_beat(REQ_APPEND), 1'b0, '0);
                n_eval = $urandom_range(1, 6);
                for (j = 0; j < n_eval; j++)
                    send_beat(rand_beat(REQ_EVAL), 1'b0, '0);
            end
            else if (kind < 80)
            begin
                send_beat(rand_beat(REQ_CLEAR), 1'b0, '0);
                n_over = MAX_POINTS + $urandom_range(1, 3);
                for (j = 0; j < n_over; j++)
                    send_beat(rand_beat(REQ_APPEND), 1'b0, '0);
                send_beat(rand_beat(REQ_EVAL), 1'b0, '0);
            end
            else if (kind < 90)
            begin
                send_beat(rand_beat(REQ_CLEAR), 1'b0, '0);
                send_beat(rand_beat(REQ_EVAL), 1'b0, '0);
                send_beat(rand_beat(REQ_UNUSED), 1'b0, '0);
            end
            else
            begin
                n_raw = $urandom_range(1, 8);
                for (j = 0; j < n_raw; j++)
                    send_beat(rand_beat(2'($urandom_range(0, 3))), 1'b0, '0);
            end
        end
    endtask

    // Output side: ready drops in random stall bursts while idling is on.
    initial
    begin
        int stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted output beat is matched against the
    // oldest expectation, one field at a time.
    always @(posedge clk)
    begin
        bpe_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (curve_results_due.size() == 0)
            begin
                report_mismatch($sformatf("result beat with none expected: %p", out_data));
            end
            else
            begin
                want = curve_results_due.pop_front();
                beats_checked++;
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_data.status, want.status));
                if (out_data.curve_x !== want.curve_x)
                    report_mismatch($sformatf("curve_x got %0d want %0d",
                                              out_data.curve_x, want.curve_x));
                if (out_data.curve_y !== want.curve_y)
                    report_mismatch($sformatf("curve_y got %0d want %0d",
                                              out_data.curve_y, want.curve_y));
                if (out_data.points_held !== want.points_held)
                    report_mismatch($sformatf("points_held got %0d want %0d",
                                              out_data.points_held, want.points_held));
            end
        end
    end

    initial
    begin
        int r;
        build_directed_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed rows go through back to back, without idling.
        idle_on = 1'b0;
        for (r = 0; r < directed_rows.size(); r++)
        begin
            send_beat(directed_rows[r].beat, directed_rows[r].has_fixed,
                      directed_rows[r].fixed_result);
        end

        run_random_sequences(RANDOM_BEATS);
        in_valid <= 1'b0;
        idle_on = 1'b0;

        while (curve_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (curve_results_due.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      curve_results_due.size()));

        $display("Run covered %0d request beats and checked %0d result beats.",
                 beats_sent, beats_checked);
        $display("Curve evaluations %0d, on an empty store %0d, refused appends %0d.",
                 evals_done, evals_empty, appends_refused);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
